### rtl/cmkms_pkg.sv
// Package for the clock mode-key menu sequencer.
// Holds mode, class, action and display codes, the register indexes and the result struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cmkms_pkg;

   localparam int MODE_WIDTH   = 4;
   localparam int CLASS_WIDTH  = 2;
   localparam int ACTION_WIDTH = 3;
   localparam int BLINK_WIDTH  = 2;
   localparam int BRIGHT_WIDTH = 2;
   localparam int NOW_WIDTH    = 32;
   localparam int THR_WIDTH    = 16;
   localparam int CSR_IDX_WIDTH = 1;

   localparam int REQ_TDATA_WIDTH = 48;
   localparam int RSP_TDATA_WIDTH = 16;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LONG_PRESS = 1'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CLICK      = 1'd1;

   localparam logic [THR_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;
   localparam logic [THR_WIDTH-1:0] CLICK_RESET      = 16'd50;

   localparam logic [MODE_WIDTH-1:0] MODE_TIME        = 4'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_TEMP        = 4'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_SECONDS     = 4'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_HOUR_ADJ    = 4'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_MINUTE_ADJ  = 4'd4;
   localparam logic [MODE_WIDTH-1:0] MODE_ALARM_EN    = 4'd5;
   localparam logic [MODE_WIDTH-1:0] MODE_ALARM_HOUR  = 4'd6;
   localparam logic [MODE_WIDTH-1:0] MODE_ALARM_MIN   = 4'd7;
   localparam logic [MODE_WIDTH-1:0] MODE_TEMP_SHOW   = 4'd8;
   localparam logic [MODE_WIDTH-1:0] MODE_TEMP_HIDE   = 4'd9;
   localparam logic [MODE_WIDTH-1:0] MODE_BRIGHT      = 4'd10;
   localparam logic [MODE_WIDTH-1:0] MODE_BRIGHT_HI   = 4'd11;
   localparam logic [MODE_WIDTH-1:0] MODE_BRIGHT_LO   = 4'd12;
   localparam logic [MODE_WIDTH-1:0] MODE_RING_EN     = 4'd13;
   localparam logic [MODE_WIDTH-1:0] MODE_RING_START  = 4'd14;
   localparam logic [MODE_WIDTH-1:0] MODE_RING_STOP   = 4'd15;

   localparam logic [CLASS_WIDTH-1:0] CLS_NONE  = 2'd0;
   localparam logic [CLASS_WIDTH-1:0] CLS_CLICK = 2'd1;
   localparam logic [CLASS_WIDTH-1:0] CLS_LONG  = 2'd2;

   localparam logic [ACTION_WIDTH-1:0] ACT_NONE       = 3'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_STOP_ALARM = 3'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_ENTER      = 3'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_ZERO_SEC   = 3'd3;
   localparam logic [ACTION_WIDTH-1:0] ACT_NEXT       = 3'd4;
   localparam logic [ACTION_WIDTH-1:0] ACT_COMMIT     = 3'd5;
   localparam logic [ACTION_WIDTH-1:0] ACT_ABANDON    = 3'd6;

   localparam logic [BLINK_WIDTH-1:0] BL_KEEP = 2'd0;
   localparam logic [BLINK_WIDTH-1:0] BL_ALL  = 2'd1;
   localparam logic [BLINK_WIDTH-1:0] BL_NONE = 2'd2;

   localparam logic [BRIGHT_WIDTH-1:0] BR_NONE   = 2'd0;
   localparam logic [BRIGHT_WIDTH-1:0] BR_WEAK   = 2'd1;
   localparam logic [BRIGHT_WIDTH-1:0] BR_STRONG = 2'd2;

   localparam logic [0:0] OP_PRESS   = 1'b0;
   localparam logic [0:0] OP_RELEASE = 1'b1;

   typedef struct packed {
      logic [BRIGHT_WIDTH-1:0] brightness_set;
      logic [BLINK_WIDTH-1:0]  blink_set;
      logic [ACTION_WIDTH-1:0] action;
      logic [CLASS_WIDTH-1:0]  press_class;
      logic [MODE_WIDTH-1:0]   new_mode;
   } result_type;

   typedef struct packed {
      logic                  hourly_ring_enabled;
      logic                  brightness_saving_off;
      logic                  temp_show_nonzero;
      logic                  alarm_enabled;
      logic                  alarm_ringing;
      logic [MODE_WIDTH-1:0] mode_in;
      logic [NOW_WIDTH-1:0]  now_ticks;
   } item_type;

endpackage

`default_nettype wire

### rtl/clock_mode_key_menu_sequencer.sv
// Top level of the clock mode-key menu sequencer: press timing, classification, menu step.
// Depends on cmkms_pkg.
//
//  channel  | dir | beat contents
//  req_     | in  | tuser: op; tdata: now_ticks, mode_in, five status flags
//  rsp_     | out | tdata: new_mode, press_class, action, blink_set, brightness_set
//  csr_     | in  | index, 16-bit threshold
//
// One beat per cycle while rsp_ accepts; a result passes from its request beat through the
// input register, then the result register. The press stamp updates as a press beat leaves
// the input register. Reset clears the valids, the stamp and loads the default thresholds.
// A stalled rsp_ holds off req_tready while the input register is full; csr_ never stalls.
`timescale 1ns / 1ps
`default_nettype none

module clock_mode_key_menu_sequencer
   import cmkms_pkg::*;
#(
   parameter int TICK_WIDTH = 32
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // [31:0] now_ticks, [35:32] mode_in, [36] alarm_ringing, [37] alarm_enabled,
   // [38] temp_show_nonzero, [39] brightness_saving_off, [40] hourly_ring_enabled
   input  wire  [REQ_TDATA_WIDTH-1:0]        req_tdata,
   // [0] op
   input  wire                               req_tuser,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // [3:0] new_mode, [5:4] press_class, [8:6] action, [10:9] blink_set,
   // [12:11] brightness_set
   output logic [RSP_TDATA_WIDTH-1:0]        rsp_tdata,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [CSR_IDX_WIDTH-1:0]          csr_index,
   input  wire  [THR_WIDTH-1:0]              csr_wdata
);

   localparam int ITEM_WIDTH = $bits(item_type);
   localparam int RES_WIDTH  = $bits(result_type);

   logic [THR_WIDTH-1:0]  long_ff, long_in;
   logic [THR_WIDTH-1:0]  click_ff, click_in;
   logic [TICK_WIDTH-1:0] stamp_ff, stamp_in;

   logic                  s1_valid_ff, s1_valid_in;
   item_type              s1_item_ff, s1_item_in;
   logic                  s1_op_ff, s1_op_in;
   logic                  out_valid_ff, out_valid_in;
   result_type            out_res_ff, out_res_in;

   logic                  out_ready;
   logic                  s1_adv;
   logic                  req_acc;
   logic [TICK_WIDTH-1:0] now_w;
   logic [TICK_WIDTH-1:0] held;
   logic [CLASS_WIDTH-1:0] cls;
   result_type            res;
   result_type            clk_res;

   assign csr_ready  = 1'b1;
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_ready;
   assign req_tready = !s1_valid_ff || out_ready;
   assign req_acc    = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_WIDTH-RES_WIDTH){1'b0}}, out_res_ff};

   // thresholds
   always_comb begin
      long_in  = long_ff;
      click_in = click_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LONG_PRESS: long_in  = csr_wdata;
            CSR_CLICK:      click_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      s1_op_in    = s1_op_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
         s1_item_in  = item_type'(req_tdata[ITEM_WIDTH-1:0]);
         s1_op_in    = req_tuser;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // classification
   assign now_w = TICK_WIDTH'(s1_item_ff.now_ticks);
   assign held  = now_w - stamp_ff;

   always_comb begin
      if (stamp_ff > now_w) begin
         cls = CLS_CLICK;
      end else if (held > TICK_WIDTH'(long_ff)) begin
         cls = CLS_LONG;
      end else if (held > TICK_WIDTH'(click_ff)) begin
         cls = CLS_CLICK;
      end else begin
         cls = CLS_NONE;
      end
   end

   // menu step on a click
   always_comb begin
      clk_res.press_class    = CLS_CLICK;
      clk_res.action         = ACT_NEXT;
      clk_res.blink_set      = BL_NONE;
      clk_res.brightness_set = BR_NONE;
      clk_res.new_mode       = MODE_TIME;
      case (s1_item_ff.mode_in)
         MODE_TIME, MODE_TEMP: begin
            clk_res.new_mode  = MODE_HOUR_ADJ;
            clk_res.action    = ACT_ENTER;
            clk_res.blink_set = BL_ALL;
         end
         MODE_SECONDS: begin
            clk_res.new_mode  = MODE_SECONDS;
            clk_res.action    = ACT_ZERO_SEC;
            clk_res.blink_set = BL_KEEP;
         end
         MODE_HOUR_ADJ: begin
            clk_res.new_mode  = MODE_MINUTE_ADJ;
            clk_res.blink_set = BL_ALL;
         end
         MODE_MINUTE_ADJ: clk_res.new_mode = MODE_ALARM_EN;
         MODE_ALARM_EN: begin
            clk_res.new_mode  = s1_item_ff.alarm_enabled ? MODE_ALARM_HOUR : MODE_TEMP_SHOW;
            clk_res.blink_set = BL_ALL;
         end
         MODE_ALARM_HOUR: begin
            clk_res.new_mode  = MODE_ALARM_MIN;
            clk_res.blink_set = BL_ALL;
         end
         MODE_ALARM_MIN: clk_res.new_mode = MODE_TEMP_SHOW;
         MODE_TEMP_SHOW: clk_res.new_mode =
            s1_item_ff.temp_show_nonzero ? MODE_TEMP_HIDE : MODE_BRIGHT;
         MODE_TEMP_HIDE: clk_res.new_mode = MODE_BRIGHT;
         MODE_BRIGHT: clk_res.new_mode =
            s1_item_ff.brightness_saving_off ? MODE_BRIGHT_HI : MODE_RING_EN;
         MODE_BRIGHT_HI: begin
            clk_res.new_mode       = MODE_BRIGHT_LO;
            clk_res.brightness_set = BR_WEAK;
         end
         MODE_BRIGHT_LO: begin
            clk_res.new_mode       = MODE_RING_EN;
            clk_res.brightness_set = BR_STRONG;
         end
         MODE_RING_EN: begin
            if (s1_item_ff.hourly_ring_enabled) begin
               clk_res.new_mode = MODE_RING_START;
            end else begin
               clk_res.new_mode = MODE_TIME;
               clk_res.action   = ACT_COMMIT;
            end
         end
         MODE_RING_START: clk_res.new_mode = MODE_RING_STOP;
         default: begin
            clk_res.new_mode  = MODE_TIME;
            clk_res.action    = ACT_COMMIT;
            clk_res.blink_set = BL_KEEP;
         end
      endcase
   end

   always_comb begin
      res.new_mode       = s1_item_ff.mode_in;
      res.press_class    = CLS_NONE;
      res.action         = ACT_NONE;
      res.blink_set      = BL_KEEP;
      res.brightness_set = BR_NONE;
      if (s1_op_ff == OP_RELEASE && cls != CLS_NONE) begin
         res.press_class = cls;
         if (s1_item_ff.alarm_ringing) begin
            res.action = ACT_STOP_ALARM;
         end else if (cls == CLS_LONG) begin
            if (s1_item_ff.mode_in >= MODE_HOUR_ADJ) begin
               res.new_mode = MODE_TIME;
               res.action   = ACT_ABANDON;
            end
         end else begin
            res = clk_res;
         end
      end
   end

   always_comb begin
      stamp_in     = stamp_ff;
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
         out_res_in   = res;
         if (s1_op_ff == OP_PRESS) begin
            stamp_in = now_w;
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ff      <= LONG_PRESS_RESET;
         click_ff     <= CLICK_RESET;
         stamp_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         long_ff      <= long_in;
         click_ff     <= click_in;
         stamp_ff     <= stamp_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      s1_op_ff   <= s1_op_in;
      out_res_ff <= out_res_in;
   end

`ifndef SYNTHESIS
   a_stop_alarm_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_res_ff.action == ACT_STOP_ALARM |->
         out_res_ff.blink_set == BL_KEEP && out_res_ff.brightness_set == BR_NONE)
      else $error("stop-alarm result drives display fields");

   a_enter_hour: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_res_ff.action == ACT_ENTER |->
         out_res_ff.new_mode == MODE_HOUR_ADJ && out_res_ff.press_class == CLS_CLICK)
      else $error("enter-settings result not at set-hour item");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && !rsp_tready |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("input register lost an item during a stall");

   a_press_stamp: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_op_ff == OP_PRESS |=> stamp_ff == $past(now_w))
      else $error("press beat did not record its stamp");
`endif

endmodule

`default_nettype wire
